FILE: hdl/trra_pkg.sv
// ---------------------------------------------------------------------------
// Tagged range reservation allocator package
// Types, constants and helper functions shared by the allocator modules.
// ---------------------------------------------------------------------------
package trra_pkg;

    localparam int MAX_EXTENTS = 64;
    localparam int IDX_W       = $clog2(MAX_EXTENTS);
    localparam int RA_W        = IDX_W + 1;
    localparam int RAM_DEPTH   = 2 * MAX_EXTENTS;
    localparam int ADDR_W      = 48;
    localparam int TAG_W       = 16;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_EXTENTS - 1);

    localparam logic [1:0] CMD_INIT  = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_FREE  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_NOT_FREE = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [1:0] REG_POOL_BASE = 2'd0;
    localparam logic [1:0] REG_POOL_SIZE = 2'd1;
    localparam logic [1:0] REG_OFFSET    = 2'd2;

    typedef struct packed {
        logic [1:0]        command;
        logic [TAG_W-1:0]  tag;
        logic [ADDR_W-1:0] first_address;
        logic [ADDR_W-1:0] limit_address;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] pool_offset;
    } t_rsp;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [TAG_W-1:0]  tag;
        logic [ADDR_W-1:0] s;
        logic [ADDR_W-1:0] e;
    } t_job;

    typedef struct packed {
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] limit;
    } t_fent;

    typedef struct packed {
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] limit;
        logic [TAG_W-1:0]  tag;
    } t_uent;

    typedef struct packed {
        logic            we;
        logic [RA_W-1:0] waddr;
        t_fent           wdata;
        logic [RA_W-1:0] raddr;
    } t_fram_req;

    typedef struct packed {
        logic            we;
        logic [RA_W-1:0] waddr;
        t_uent           wdata;
        logic [RA_W-1:0] raddr;
    } t_uram_req;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] idx;
    } t_slot;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CP_RD,
        S_CP_WR,
        S_AL_RD,
        S_AL_CK,
        S_AL_WR1,
        S_AL_WR2,
        S_FR_RD,
        S_FR_CK,
        S_FS_RD,
        S_FS_CK,
        S_FS_WR,
        S_FU_WR,
        S_FU_WR2
    } t_state;

    // Lowest index whose valid bit is clear.
    function automatic t_slot find_slot(input logic [MAX_EXTENTS-1:0] valid);
        t_slot res;
        res.ok  = 1'b0;
        res.idx = '0;
        for (int i = MAX_EXTENTS - 1; i >= 0; i--) begin
            if (!valid[i]) begin
                res.ok  = 1'b1;
                res.idx = IDX_W'(i);
            end
        end
        return res;
    endfunction

endpackage

FILE: hdl/trra_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module trra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/trra_core.sv
// ---------------------------------------------------------------------------
// Allocator sequencer
// Copies the committed tables into the work bank, runs allocate or free on
// the work bank and commits it by swapping banks when the request succeeds.
// ---------------------------------------------------------------------------
module trra_core import trra_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_job              i_job,
    input  logic [ADDR_W-1:0] i_base,
    input  logic [ADDR_W-1:0] i_size,
    output logic              o_busy,
    output logic              o_done,
    output t_rsp              o_rsp,
    output t_fram_req         o_fram,
    input  t_fent             i_fram_rdata,
    output t_uram_req         o_uram,
    input  t_uent             i_uram_rdata
);

    t_state                 r_state, n_state;
    logic                   r_bank, n_bank;
    logic [MAX_EXTENTS-1:0] r_fv_c, n_fv_c, r_fv_w, n_fv_w;
    logic [MAX_EXTENTS-1:0] r_uv_c, n_uv_c, r_uv_w, n_uv_w;
    logic                   r_done, n_done;

    t_job              r_job, n_job;
    logic [IDX_W-1:0]  r_ptr, n_ptr, r_ui, n_ui, r_hit, n_hit;
    logic [IDX_W-1:0]  r_left, n_left, r_right, n_right;
    logic [ADDR_W-1:0] r_ff, n_ff, r_fl, n_fl, r_uf, n_uf, r_ul, n_ul;
    logic [ADDR_W-1:0] r_lo, n_lo, r_hi, n_hi, r_lff, n_lff, r_rfl, n_rfl;
    logic              r_lv, n_lv, r_rv, n_rv;
    logic [1:0]        r_status, n_status;
    logic [ADDR_W-1:0] r_off, n_off;

    logic              wb;
    t_slot             fslot, uslot;
    logic [ADDR_W:0]   init_lim;
    logic              split;

    assign wb       = ~r_bank;
    assign fslot    = find_slot(r_fv_w);
    assign uslot    = find_slot(r_uv_w);
    assign init_lim = {1'b0, i_base} + {1'b0, i_size};
    assign split    = (r_ff < r_job.s) && (r_job.e < r_fl);

    always_comb begin
        logic commit;
        logic next_used;
        logic off_set;
        n_state   = r_state;
        n_bank    = r_bank;
        n_fv_c    = r_fv_c;
        n_fv_w    = r_fv_w;
        n_uv_c    = r_uv_c;
        n_uv_w    = r_uv_w;
        n_done    = 1'b0;
        n_job     = r_job;
        n_ptr     = r_ptr;
        n_ui      = r_ui;
        n_hit     = r_hit;
        n_left    = r_left;
        n_right   = r_right;
        n_ff      = r_ff;
        n_fl      = r_fl;
        n_uf      = r_uf;
        n_ul      = r_ul;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_lff     = r_lff;
        n_rfl     = r_rfl;
        n_lv      = r_lv;
        n_rv      = r_rv;
        n_status  = r_status;
        n_off     = r_off;
        o_fram    = '0;
        o_uram    = '0;
        commit    = 1'b0;
        next_used = 1'b0;
        off_set   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_job = i_job;
                    n_ptr = '0;
                    n_ui  = '0;
                    if (i_job.cmd == CMD_INIT) begin
                        n_done = 1'b1;
                        if (init_lim[ADDR_W]) begin
                            n_status = ST_INVALID;
                        end else begin
                            n_status       = ST_OK;
                            o_fram.we      = 1'b1;
                            o_fram.waddr   = {r_bank, IDX_W'(0)};
                            o_fram.wdata   = '{first: i_base, limit: init_lim[ADDR_W-1:0]};
                            n_fv_c         = '0;
                            n_fv_c[0]      = (i_base < init_lim[ADDR_W-1:0]);
                            n_uv_c         = '0;
                        end
                    end else if (i_job.cmd != CMD_ALLOC && i_job.cmd != CMD_FREE) begin
                        n_done   = 1'b1;
                        n_status = ST_INVALID;
                    end else if (i_job.s >= i_job.e) begin
                        n_done   = 1'b1;
                        n_status = ST_INVALID;
                    end else begin
                        n_state = S_CP_RD;
                    end
                end
            end
            S_CP_RD: begin
                o_fram.raddr = {r_bank, r_ptr};
                o_uram.raddr = {r_bank, r_ptr};
                n_state      = S_CP_WR;
            end
            S_CP_WR: begin
                o_fram.we    = 1'b1;
                o_fram.waddr = {wb, r_ptr};
                o_fram.wdata = i_fram_rdata;
                o_uram.we    = 1'b1;
                o_uram.waddr = {wb, r_ptr};
                o_uram.wdata = i_uram_rdata;
                if (r_ptr == IDX_LAST) begin
                    n_fv_w  = r_fv_c;
                    n_uv_w  = r_uv_c;
                    n_ptr   = '0;
                    n_state = (r_job.cmd == CMD_ALLOC) ? S_AL_RD : S_FR_RD;
                end else begin
                    n_ptr   = r_ptr + 1'b1;
                    n_state = S_CP_RD;
                end
            end
            S_AL_RD: begin
                o_fram.raddr = {wb, r_ptr};
                n_state      = S_AL_CK;
            end
            S_AL_CK: begin
                if (r_fv_w[r_ptr] && i_fram_rdata.first <= r_job.s
                        && i_fram_rdata.limit >= r_job.e) begin
                    n_hit   = r_ptr;
                    n_ff    = i_fram_rdata.first;
                    n_fl    = i_fram_rdata.limit;
                    n_state = S_AL_WR1;
                end else if (r_ptr == IDX_LAST) begin
                    n_done   = 1'b1;
                    n_status = ST_NOT_FREE;
                    n_state  = S_IDLE;
                end else begin
                    n_ptr   = r_ptr + 1'b1;
                    n_state = S_AL_RD;
                end
            end
            S_AL_WR1: begin
                if ((split && !fslot.ok) || !uslot.ok) begin
                    n_done   = 1'b1;
                    n_status = ST_FULL;
                    n_state  = S_IDLE;
                end else begin
                    o_uram.we           = 1'b1;
                    o_uram.waddr        = {wb, uslot.idx};
                    o_uram.wdata        = '{first: r_job.s, limit: r_job.e, tag: r_job.tag};
                    n_uv_w[uslot.idx]   = 1'b1;
                    if (r_ff < r_job.s) begin
                        o_fram.we    = 1'b1;
                        o_fram.waddr = {wb, r_hit};
                        o_fram.wdata = '{first: r_ff, limit: r_job.s};
                        if (split) begin
                            n_state = S_AL_WR2;
                        end else begin
                            commit  = 1'b1;
                            off_set = 1'b1;
                        end
                    end else if (r_job.e < r_fl) begin
                        o_fram.we    = 1'b1;
                        o_fram.waddr = {wb, r_hit};
                        o_fram.wdata = '{first: r_job.e, limit: r_fl};
                        commit       = 1'b1;
                        off_set      = 1'b1;
                    end else begin
                        n_fv_w[r_hit] = 1'b0;
                        commit        = 1'b1;
                        off_set       = 1'b1;
                    end
                end
            end
            S_AL_WR2: begin
                o_fram.we         = 1'b1;
                o_fram.waddr      = {wb, fslot.idx};
                o_fram.wdata      = '{first: r_job.e, limit: r_fl};
                n_fv_w[fslot.idx] = 1'b1;
                commit            = 1'b1;
                off_set           = 1'b1;
            end
            S_FR_RD: begin
                o_uram.raddr = {wb, r_ui};
                n_state      = S_FR_CK;
            end
            S_FR_CK: begin
                if (r_uv_w[r_ui] && i_uram_rdata.tag == r_job.tag
                        && i_uram_rdata.first < r_job.e && r_job.s < i_uram_rdata.limit) begin
                    n_uf    = i_uram_rdata.first;
                    n_ul    = i_uram_rdata.limit;
                    n_lo    = (i_uram_rdata.first > r_job.s) ? i_uram_rdata.first : r_job.s;
                    n_hi    = (i_uram_rdata.limit < r_job.e) ? i_uram_rdata.limit : r_job.e;
                    n_lv    = 1'b0;
                    n_rv    = 1'b0;
                    n_ptr   = '0;
                    n_state = S_FS_RD;
                end else begin
                    next_used = 1'b1;
                end
            end
            S_FS_RD: begin
                o_fram.raddr = {wb, r_ptr};
                n_state      = S_FS_CK;
            end
            S_FS_CK: begin
                if (r_fv_w[r_ptr]) begin
                    if (!r_lv && i_fram_rdata.limit == r_lo) begin
                        n_lv   = 1'b1;
                        n_left = r_ptr;
                        n_lff  = i_fram_rdata.first;
                    end
                    if (!r_rv && i_fram_rdata.first == r_hi) begin
                        n_rv    = 1'b1;
                        n_right = r_ptr;
                        n_rfl   = i_fram_rdata.limit;
                    end
                end
                if (r_ptr == IDX_LAST) begin
                    n_state = S_FS_WR;
                end else begin
                    n_ptr   = r_ptr + 1'b1;
                    n_state = S_FS_RD;
                end
            end
            S_FS_WR: begin
                n_state = S_FU_WR;
                if (r_lv && r_rv) begin
                    o_fram.we       = 1'b1;
                    o_fram.waddr    = {wb, r_left};
                    o_fram.wdata    = '{first: r_lff, limit: r_rfl};
                    n_fv_w[r_right] = 1'b0;
                end else if (r_lv) begin
                    o_fram.we    = 1'b1;
                    o_fram.waddr = {wb, r_left};
                    o_fram.wdata = '{first: r_lff, limit: r_hi};
                end else if (r_rv) begin
                    o_fram.we    = 1'b1;
                    o_fram.waddr = {wb, r_right};
                    o_fram.wdata = '{first: r_lo, limit: r_rfl};
                end else if (fslot.ok) begin
                    o_fram.we         = 1'b1;
                    o_fram.waddr      = {wb, fslot.idx};
                    o_fram.wdata      = '{first: r_lo, limit: r_hi};
                    n_fv_w[fslot.idx] = 1'b1;
                end else begin
                    n_done   = 1'b1;
                    n_status = ST_FULL;
                    n_state  = S_IDLE;
                end
            end
            S_FU_WR: begin
                if (r_uf < r_job.s) begin
                    o_uram.we    = 1'b1;
                    o_uram.waddr = {wb, r_ui};
                    o_uram.wdata = '{first: r_uf, limit: r_job.s, tag: r_job.tag};
                    if (r_job.e < r_ul) begin
                        n_state = S_FU_WR2;
                    end else begin
                        next_used = 1'b1;
                    end
                end else if (r_job.e < r_ul) begin
                    o_uram.we    = 1'b1;
                    o_uram.waddr = {wb, r_ui};
                    o_uram.wdata = '{first: r_job.e, limit: r_ul, tag: r_job.tag};
                    next_used    = 1'b1;
                end else begin
                    n_uv_w[r_ui] = 1'b0;
                    next_used    = 1'b1;
                end
            end
            S_FU_WR2: begin
                if (uslot.ok) begin
                    o_uram.we         = 1'b1;
                    o_uram.waddr      = {wb, uslot.idx};
                    o_uram.wdata      = '{first: r_job.e, limit: r_ul, tag: r_job.tag};
                    n_uv_w[uslot.idx] = 1'b1;
                    next_used         = 1'b1;
                end else begin
                    n_done   = 1'b1;
                    n_status = ST_FULL;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (next_used) begin
            if (r_ui == IDX_LAST) begin
                commit = 1'b1;
            end else begin
                n_ui    = r_ui + 1'b1;
                n_state = S_FR_RD;
            end
        end

        if (commit) begin
            n_bank   = ~r_bank;
            n_fv_c   = n_fv_w;
            n_uv_c   = n_uv_w;
            n_done   = 1'b1;
            n_status = ST_OK;
            n_state  = S_IDLE;
        end

        if (n_done) begin
            n_off = off_set ? (r_job.s - i_base) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bank  <= 1'b0;
            r_fv_c  <= '0;
            r_fv_w  <= '0;
            r_uv_c  <= '0;
            r_uv_w  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bank  <= n_bank;
            r_fv_c  <= n_fv_c;
            r_fv_w  <= n_fv_w;
            r_uv_c  <= n_uv_c;
            r_uv_w  <= n_uv_w;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job    <= n_job;
        r_ptr    <= n_ptr;
        r_ui     <= n_ui;
        r_hit    <= n_hit;
        r_left   <= n_left;
        r_right  <= n_right;
        r_ff     <= n_ff;
        r_fl     <= n_fl;
        r_uf     <= n_uf;
        r_ul     <= n_ul;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_lff    <= n_lff;
        r_rfl    <= n_rfl;
        r_lv     <= n_lv;
        r_rv     <= n_rv;
        r_status <= n_status;
        r_off    <= n_off;
    end

    assign o_busy            = (r_state != S_IDLE);
    assign o_done            = r_done;
    assign o_rsp.status      = r_status;
    assign o_rsp.pool_offset = r_off;

endmodule

FILE: hdl/tagged_range_reservation_allocator.sv
// ---------------------------------------------------------------------------
// Tagged range reservation allocator
// Extent allocator with a coalescing free table and a tagged used table.
// ---------------------------------------------------------------------------
// A request is taken when i_start is high and o_busy is low. It carries a
// command (reinitialize, allocate, free), a tag and a virtual range that is
// translated by the offset register. Exactly one response per request comes
// back on o_rsp with o_done high for one cycle; the receiver cannot stall it.
// Configuration registers (pool base, pool size, offset) are written on the
// i_cfg_valid/o_cfg_ready channel, which is ready only while idle and no
// request is being presented.
// Reinitialize, unknown commands and rejected ranges answer in the cycle after
// the request. Allocate and free first copy the committed tables into a second
// bank, reading and then writing each of the MAX_EXTENTS entries, then scan the
// work bank entry by entry; free rescans the free table for each overlapping
// allocation. The scans are bound by the single read port of each table
// memory. A successful request swaps banks; a failed one leaves the committed
// bank untouched. Reset empties both tables and clears the configuration
// registers.
// ---------------------------------------------------------------------------
module tagged_range_reservation_allocator import trra_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  t_req              i_req,
    output logic              o_done,
    output t_rsp              o_rsp,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [ADDR_W-1:0] i_cfg_data
);

    logic [ADDR_W-1:0] r_base, r_size, r_offset;
    t_job              job;
    t_fram_req         fram;
    t_uram_req         uram;
    t_fent             fram_rdata;
    t_uent             uram_rdata;
    logic              busy;
    logic              cfg_ready;

    assign cfg_ready = !busy && !i_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_size   <= '0;
            r_offset <= '0;
        end else if (i_cfg_valid && cfg_ready) begin
            if (i_cfg_index == REG_POOL_BASE) begin
                r_base <= i_cfg_data;
            end
            if (i_cfg_index == REG_POOL_SIZE) begin
                r_size <= i_cfg_data;
            end
            if (i_cfg_index == REG_OFFSET) begin
                r_offset <= i_cfg_data;
            end
        end
    end

    assign o_cfg_ready = cfg_ready;

    assign job.cmd = i_req.command;
    assign job.tag = i_req.tag;
    assign job.s   = i_req.first_address + r_offset;
    assign job.e   = i_req.limit_address + r_offset;

    trra_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start && !busy),
        .i_job        (job),
        .i_base       (r_base),
        .i_size       (r_size),
        .o_busy       (busy),
        .o_done       (o_done),
        .o_rsp        (o_rsp),
        .o_fram       (fram),
        .i_fram_rdata (fram_rdata),
        .o_uram       (uram),
        .i_uram_rdata (uram_rdata)
    );

    trra_ram #(
        .WIDTH ($bits(t_fent)),
        .DEPTH (RAM_DEPTH)
    ) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (fram.we),
        .i_waddr (fram.waddr),
        .i_wdata (fram.wdata),
        .i_raddr (fram.raddr),
        .o_rdata (fram_rdata)
    );

    trra_ram #(
        .WIDTH ($bits(t_uent)),
        .DEPTH (RAM_DEPTH)
    ) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (uram.we),
        .i_waddr (uram.waddr),
        .i_wdata (uram.wdata),
        .i_raddr (uram.raddr),
        .o_rdata (uram_rdata)
    );

    assign o_busy = busy;

endmodule

FILE: hdl/trra_checker.sv
// ---------------------------------------------------------------------------
// Allocator port checker
// Checks request and response ordering seen at the top-level ports.
// ---------------------------------------------------------------------------
module trra_checker import trra_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              o_busy,
    input t_req              i_req,
    input logic              o_done,
    input t_rsp              o_rsp,
    input logic              i_cfg_valid,
    input logic              o_cfg_ready
);

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_done))
        else $error("Accepted request neither started nor answered.");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("Response shown while still busy.");

    a_unknown_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_req.command != CMD_INIT && i_req.command != CMD_ALLOC
            && i_req.command != CMD_FREE)
        |=> (o_done && o_rsp.status == ST_INVALID))
        else $error("Unknown command not rejected at once.");

    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != ST_OK) |-> (o_rsp.pool_offset == '0))
        else $error("Failed request returned a nonzero offset.");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |-> (!o_busy && !i_start))
        else $error("Configuration write taken while a request is in flight.");

endmodule

bind tagged_range_reservation_allocator trra_checker u_trra_checker (.*);

FILE: verif/tb.sv
// ---------------------------------------------------------------------------
// Tagged range reservation allocator testbench
// Drives reinitialize, allocate and free requests with random idle bursts,
// predicts every response from a software copy of both extent tables and
// checks each response in order. Pool and offset registers are changed
// between phases while the block is idle.
// ---------------------------------------------------------------------------
module tb;
    import trra_pkg::*;

    localparam logic [ADDR_W-1:0] AMASK = '1;

    class alloc_scoreboard;
        logic [ADDR_W-1:0] fr_first[MAX_EXTENTS];
        logic [ADDR_W-1:0] fr_limit[MAX_EXTENTS];
        bit                fr_valid[MAX_EXTENTS];
        logic [ADDR_W-1:0] us_first[MAX_EXTENTS];
        logic [ADDR_W-1:0] us_limit[MAX_EXTENTS];
        logic [TAG_W-1:0]  us_tag[MAX_EXTENTS];
        bit                us_valid[MAX_EXTENTS];
        logic [ADDR_W-1:0] pool_base;
        logic [ADDR_W-1:0] pool_size;
        logic [ADDR_W-1:0] addr_offset;
        t_rsp              pending_rsp[$];
        int                mismatches;

        function new();
            pool_base = '0;
            pool_size = '0;
            addr_offset = '0;
            mismatches = 0;
            foreach (fr_valid[i]) begin
                fr_valid[i] = 0;
                us_valid[i] = 0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [ADDR_W-1:0] val);
            case (idx)
                REG_POOL_BASE: pool_base = val;
                REG_POOL_SIZE: pool_size = val;
                REG_OFFSET:    addr_offset = val;
                default: ;
            endcase
        endfunction

        function int open_free_slot();
            for (int i = 0; i < MAX_EXTENTS; i++) if (!fr_valid[i]) return i;
            return -1;
        endfunction

        function int open_used_slot();
            for (int i = 0; i < MAX_EXTENTS; i++) if (!us_valid[i]) return i;
            return -1;
        endfunction

        function bit give_back(logic [ADDR_W-1:0] s, logic [ADDR_W-1:0] e);
            int lft;
            int rgt;
            int k;
            lft = -1;
            rgt = -1;
            if (s >= e) return 1;
            for (int i = 0; i < MAX_EXTENTS; i++) begin
                if (fr_valid[i]) begin
                    if (lft < 0 && fr_limit[i] == s) lft = i;
                    if (rgt < 0 && fr_first[i] == e) rgt = i;
                end
            end
            if (lft >= 0 && rgt >= 0) begin
                fr_limit[lft] = fr_limit[rgt];
                fr_valid[rgt] = 0;
            end else if (lft >= 0) begin
                fr_limit[lft] = e;
            end else if (rgt >= 0) begin
                fr_first[rgt] = s;
            end else begin
                k = open_free_slot();
                if (k < 0) return 0;
                fr_first[k] = s;
                fr_limit[k] = e;
                fr_valid[k] = 1;
            end
            return 1;
        endfunction

        function bit record_used(logic [ADDR_W-1:0] s, logic [ADDR_W-1:0] e,
                                 logic [TAG_W-1:0] tg);
            int k;
            if (s >= e) return 1;
            k = open_used_slot();
            if (k < 0) return 0;
            us_first[k] = s;
            us_limit[k] = e;
            us_tag[k] = tg;
            us_valid[k] = 1;
            return 1;
        endfunction

        function logic [1:0] carve(logic [ADDR_W-1:0] s, logic [ADDR_W-1:0] e,
                                   logic [TAG_W-1:0] tg);
            int hit;
            int k;
            logic [ADDR_W-1:0] ff;
            logic [ADDR_W-1:0] fl;
            hit = -1;
            for (int i = 0; i < MAX_EXTENTS; i++) begin
                if (hit < 0 && fr_valid[i] && fr_first[i] <= s && fr_limit[i] >= e)
                    hit = i;
            end
            if (hit < 0) return ST_NOT_FREE;
            ff = fr_first[hit];
            fl = fr_limit[hit];
            if (ff < s) begin
                fr_limit[hit] = s;
                if (e < fl) begin
                    k = open_free_slot();
                    if (k < 0) return ST_FULL;
                    fr_first[k] = e;
                    fr_limit[k] = fl;
                    fr_valid[k] = 1;
                end
            end else if (e < fl) begin
                fr_first[hit] = e;
            end else begin
                fr_valid[hit] = 0;
            end
            return record_used(s, e, tg) ? ST_OK : ST_FULL;
        endfunction

        function logic [1:0] release_range(logic [ADDR_W-1:0] s, logic [ADDR_W-1:0] e,
                                           logic [TAG_W-1:0] tg);
            logic [ADDR_W-1:0] uf;
            logic [ADDR_W-1:0] ul;
            for (int i = 0; i < MAX_EXTENTS; i++) begin
                if (us_valid[i] && us_tag[i] == tg) begin
                    uf = us_first[i];
                    ul = us_limit[i];
                    if (uf < e && s < ul) begin
                        if (!give_back(uf > s ? uf : s, ul < e ? ul : e)) return ST_FULL;
                        if (uf < s) begin
                            us_limit[i] = s;
                            if (!record_used(e, ul, tg)) return ST_FULL;
                        end else if (e < ul) begin
                            us_first[i] = e;
                        end else begin
                            us_valid[i] = 0;
                        end
                    end
                end
            end
            return ST_OK;
        endfunction

        function void note_request(t_req rq);
            t_rsp rs;
            logic [ADDR_W:0] lim;
            logic [ADDR_W-1:0] s;
            logic [ADDR_W-1:0] e;
            logic [ADDR_W-1:0] sv_ff[MAX_EXTENTS];
            logic [ADDR_W-1:0] sv_fl[MAX_EXTENTS];
            bit                sv_fv[MAX_EXTENTS];
            logic [ADDR_W-1:0] sv_uf[MAX_EXTENTS];
            logic [ADDR_W-1:0] sv_ul[MAX_EXTENTS];
            logic [TAG_W-1:0]  sv_ut[MAX_EXTENTS];
            bit                sv_uv[MAX_EXTENTS];
            rs.status = ST_OK;
            rs.pool_offset = '0;
            s = rq.first_address + addr_offset;
            e = rq.limit_address + addr_offset;
            if (rq.command == CMD_INIT) begin
                lim = {1'b0, pool_base} + {1'b0, pool_size};
                if (lim[ADDR_W]) begin
                    rs.status = ST_INVALID;
                end else begin
                    foreach (fr_valid[i]) begin
                        fr_valid[i] = 0;
                        us_valid[i] = 0;
                    end
                    if (pool_size != 0) begin
                        fr_first[0] = pool_base;
                        fr_limit[0] = lim[ADDR_W-1:0];
                        fr_valid[0] = 1;
                    end
                end
            end else if ((rq.command != CMD_ALLOC && rq.command != CMD_FREE) || s >= e) begin
                rs.status = ST_INVALID;
            end else begin
                sv_ff = fr_first; sv_fl = fr_limit; sv_fv = fr_valid;
                sv_uf = us_first; sv_ul = us_limit; sv_ut = us_tag; sv_uv = us_valid;
                rs.status = (rq.command == CMD_ALLOC) ? carve(s, e, rq.tag)
                                                      : release_range(s, e, rq.tag);
                if (rs.status == ST_OK) begin
                    if (rq.command == CMD_ALLOC) rs.pool_offset = s - pool_base;
                end else begin
                    fr_first = sv_ff; fr_limit = sv_fl; fr_valid = sv_fv;
                    us_first = sv_uf; us_limit = sv_ul; us_tag = sv_ut; us_valid = sv_uv;
                end
            end
            pending_rsp.push_back(rs);
        endfunction

        function void check_response(t_rsp got);
            t_rsp exp_rsp;
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected response %h", got);
                return;
            end
            exp_rsp = pending_rsp.pop_front();
            if (got.status !== exp_rsp.status || got.pool_offset !== exp_rsp.pool_offset) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected status %0d offset %h, got status %0d offset %h",
                             exp_rsp.status, exp_rsp.pool_offset, got.status, got.pool_offset);
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_start;
    logic              o_busy;
    t_req              i_req;
    logic              o_done;
    t_rsp              o_rsp;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index;
    logic [ADDR_W-1:0] i_cfg_data;

    alloc_scoreboard sb;
    bit              no_gaps;

    tagged_range_reservation_allocator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_req(i_req), .o_done(o_done), .o_rsp(o_rsp), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0; #2;
        i_clk = 1'b1; #2;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_response(o_rsp);
    end

    // The start line stays high from one request to the next unless an idle
    // burst is inserted; drain() lowers it.
    task automatic send_request(logic [1:0] cmd, logic [TAG_W-1:0] tg,
                                logic [ADDR_W-1:0] fa, logic [ADDR_W-1:0] la);
        t_req rq;
        int gap;
        rq.command = cmd;
        rq.tag = tg;
        rq.first_address = fa;
        rq.limit_address = la;
        if (!no_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_req <= rq;
        do @(posedge i_clk); while (o_busy);
        sb.note_request(rq);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_start <= 1'b0;
        while (sb.pending_rsp.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [ADDR_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task automatic set_pool(logic [ADDR_W-1:0] b, logic [ADDR_W-1:0] sz,
                            logic [ADDR_W-1:0] off);
        drain();
        write_reg(REG_POOL_BASE, b);
        write_reg(REG_POOL_SIZE, sz);
        write_reg(REG_OFFSET, off);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'({$urandom(), $urandom()});
    endfunction

    // Mostly well-formed allocate and free requests inside the pool window.
    task automatic random_phase(int n, logic [ADDR_W-1:0] span, int ntags);
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] l;
        logic [ADDR_W-1:0] vb;
        int pick;
        vb = sb.pool_base - sb.addr_offset;
        for (int k = 0; k < n; k++) begin
            a = vb + ADDR_W'($urandom_range(0, 32'(span)));
            l = a + ADDR_W'($urandom_range(1, 16));
            pick = $urandom_range(0, 99);
            if (pick < 48)
                send_request(CMD_ALLOC, TAG_W'($urandom_range(0, ntags - 1)), a, l);
            else if (pick < 88)
                send_request(CMD_FREE, TAG_W'($urandom_range(0, ntags - 1)), a,
                             a + ADDR_W'($urandom_range(1, 40)));
            else if (pick < 92)
                send_request(CMD_INIT, TAG_W'($urandom()), rand_addr(), rand_addr());
            else if (pick < 94)
                send_request(2'd3, TAG_W'($urandom()), a, l);
            else if (pick < 96)
                send_request(CMD_ALLOC, TAG_W'($urandom()), l, a);
            else
                send_request(2'($urandom_range(1, 2)), TAG_W'($urandom()), rand_addr(),
                             rand_addr());
        end
    endtask

    initial begin
        sb = new();
        no_gaps = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_POOL_BASE;
        i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests: empty pool, reinitialize overflow, edges and errors.
        send_request(CMD_ALLOC, 16'h0, 48'h0, 48'h10);
        send_request(CMD_INIT, 16'hFFFF, AMASK, AMASK);
        set_pool(AMASK, 48'h1, 48'h0);
        send_request(CMD_INIT, 16'h0, 48'h0, 48'h0);
        set_pool(48'h0, AMASK, 48'h0);
        send_request(CMD_INIT, 16'h0, 48'h0, 48'h0);
        send_request(CMD_ALLOC, 16'hFFFF, 48'h0, AMASK);
        send_request(CMD_FREE, 16'hFFFF, 48'h0, AMASK);
        send_request(CMD_ALLOC, 16'h1, 48'h100, 48'h100);
        send_request(CMD_FREE, 16'h1, 48'h200, 48'h100);
        send_request(2'd3, 16'h1, 48'h0, 48'h10);
        send_request(CMD_ALLOC, 16'h1, 48'h100, 48'h200);
        send_request(CMD_ALLOC, 16'h2, 48'h180, 48'h190);
        send_request(CMD_FREE, 16'h2, 48'h100, 48'h200);
        send_request(CMD_FREE, 16'h1, 48'h140, 48'h150);
        send_request(CMD_FREE, 16'h1, 48'h0, AMASK);
        send_request(CMD_FREE, 16'h1, 48'h0, AMASK);
        set_pool(48'h8000_0000_1000, 48'h400, 48'h8000_0000_0000);
        send_request(CMD_INIT, 16'h0, 48'h0, 48'h0);
        send_request(CMD_ALLOC, 16'hA5A5, 48'h1000, 48'h1400);
        send_request(CMD_FREE, 16'hA5A5, AMASK, 48'h1000);
        send_request(CMD_ALLOC, 16'h5A5A, 48'h0FFF, 48'h1001);
        set_pool(48'h0, 48'h0, 48'h0);
        send_request(CMD_INIT, 16'h0, 48'h0, 48'h0);
        send_request(CMD_ALLOC, 16'h0, 48'h0, 48'h1);

        // Small pool with few tags fills and fragments both tables.
        set_pool(48'h1000, 48'h800, AMASK);
        send_request(CMD_INIT, 16'h0, 48'h0, 48'h0);
        random_phase(220, 48'h7F0, 4);

        set_pool(48'h7FFF_FFFF_F000, 48'h200, 48'h7FFF_0000_0000);
        send_request(CMD_INIT, 16'h0, 48'h0, 48'h0);
        random_phase(150, 48'h200, 16);

        set_pool(48'hFFFF_FFFF_FC00, 48'h3FF, 48'hFFFF_FFFF_FFF0);
        send_request(CMD_INIT, 16'h0, 48'h0, 48'h0);
        random_phase(150, 48'h3F0, 2);

        set_pool(rand_addr() >> 1, 48'h300, rand_addr());
        send_request(CMD_INIT, 16'h0, 48'h0, 48'h0);
        no_gaps = 1;
        random_phase(100, 48'h300, 3);

        drain();
        if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #200000000;
        $display("status: fail");
        $finish;
    end
endmodule
